[design/xld_pkg.sv]
// Shared types and opcode constants for the x86 instruction length decoder.
package xld_pkg;

  // Kind of relative branch field found in the instruction
  typedef enum logic [2:0] {
    REL_NONE   = 3'd0,
    REL_CALL32 = 3'd1,
    REL_JMP32  = 3'd2,
    REL_JMP8   = 3'd3,
    REL_JCC8   = 3'd4,
    REL_JCC32  = 3'd5
  } rel_kind_t;

  // Prefix bytes
  localparam logic [7:0] PFX_LOCK  = 8'hF0;
  localparam logic [7:0] PFX_REPNE = 8'hF2;
  localparam logic [7:0] PFX_REP   = 8'hF3;
  localparam logic [7:0] PFX_CS    = 8'h2E;
  localparam logic [7:0] PFX_SS    = 8'h36;
  localparam logic [7:0] PFX_DS    = 8'h3E;
  localparam logic [7:0] PFX_ES    = 8'h26;
  localparam logic [7:0] PFX_FS    = 8'h64;
  localparam logic [7:0] PFX_GS    = 8'h65;
  localparam logic [7:0] PFX_OPSZ  = 8'h66;
  localparam logic [7:0] PFX_ADSZ  = 8'h67;

  // Opcodes with special handling
  localparam logic [7:0] OP_TWO_BYTE  = 8'h0F;
  localparam logic [7:0] OP_RET       = 8'hC3;
  localparam logic [7:0] OP_RET_IMM   = 8'hC2;
  localparam logic [7:0] OP_RETF_IMM  = 8'hCA;
  localparam logic [7:0] OP_GRP5      = 8'hFF;
  localparam logic [7:0] OP_CALL_REL  = 8'hE8;
  localparam logic [7:0] OP_JMP_REL32 = 8'hE9;
  localparam logic [7:0] OP_JMP_REL8  = 8'hEB;

  // One lane's view of the instruction, assuming the opcode sits at its position
  typedef struct packed {
    logic       ok;
    logic [3:0] len;
    logic [3:0] rel_pos;
    rel_kind_t  rel_kind;
    logic       has_modrm;
    logic [7:0] modrm;
    logic       ends_flow;
  } lane_res_t;

endpackage

[design/xld_lane.sv]
// Decode lane: decodes the instruction assuming its opcode starts at byte POS.
module xld_lane #(
  parameter int POS     = 0,
  parameter int MAX_LEN = 15
) (
  input  logic [7:0]         win [4],
  input  logic               op16,
  input  logic               ad16,
  output xld_pkg::lane_res_t res
);

  localparam int LW = 5;  // lane-local length width, enough for POS + 11
  localparam logic [LW-1:0] P = LW'(POS);

  function automatic logic needs_modrm(input logic [7:0] op);
    logic r;
    r = 1'b0;
    if (op < 8'h40 && op[2:0] < 3'd4) r = 1'b1;
    if (op >= 8'h80 && op <= 8'h8F) r = 1'b1;
    if (op >= 8'hD0 && op <= 8'hD3) r = 1'b1;
    if (op >= 8'hD8 && op <= 8'hDF) r = 1'b1;
    if (op == 8'h62 || op == 8'h63 || op == 8'h69 || op == 8'h6B ||
        op == 8'hC0 || op == 8'hC1 || op == 8'hC6 || op == 8'hC7 ||
        op == 8'hF6 || op == 8'hF7 || op == 8'hFE || op == xld_pkg::OP_GRP5) r = 1'b1;
    return r;
  endfunction

  function automatic logic needs_modrm_ext(input logic [7:0] op);
    return op == 8'h1F || op == 8'hAF || op == 8'hB6 || op == 8'hB7 ||
           op == 8'hBE || op == 8'hBF;
  endfunction

  function automatic logic [2:0] imm_size(input logic [7:0] op, input logic o16,
                                          input logic [2:0] reg_f);
    logic [2:0] full;
    logic [2:0] r;
    full = o16 ? 3'd2 : 3'd4;
    r    = 3'd0;
    if (op < 8'h40 && op[2:0] == 3'd4) r = 3'd1;
    else if (op < 8'h40 && op[2:0] == 3'd5) r = full;
    else if (op == 8'h6A || op == 8'hA8 || op == 8'hC0 || op == 8'hC1 || op == 8'hC6 ||
             op == 8'h6B || op == 8'h80 || op == 8'h82 || op == 8'h83) r = 3'd1;
    else if (op == 8'h68 || op == 8'h69 || op == 8'h81 || op == 8'hA9 || op == 8'hC7)
      r = full;
    else if (op == 8'hF6) r = (reg_f <= 3'd1) ? 3'd1 : 3'd0;
    else if (op == 8'hF7) r = (reg_f <= 3'd1) ? full : 3'd0;
    return r;
  endfunction

  // Bytes following the ModRM byte: SIB, SIB base displacement, displacement
  function automatic logic [3:0] modrm_extra(input logic [7:0] m, input logic [7:0] sib);
    logic [3:0] r;
    r = 4'd0;
    if (m[7:6] != 2'd3 && m[2:0] == 3'd4) begin
      r = 4'd1;
      if (m[7:6] == 2'd0 && sib[2:0] == 3'd5) r = 4'd5;
    end
    if (m[7:6] == 2'd0 && m[2:0] == 3'd5) r = r + 4'd4;
    else if (m[7:6] == 2'd1) r = r + 4'd1;
    else if (m[7:6] == 2'd2) r = r + 4'd4;
    return r;
  endfunction

  logic [7:0]          b0, b1, b2, b3;
  logic                form_ok;
  logic [LW-1:0]       len;
  logic [LW-1:0]       rpos;
  xld_pkg::rel_kind_t  rkind;
  logic                hm;
  logic [7:0]          modrm;
  logic                term;

  assign b0 = win[0];
  assign b1 = win[1];
  assign b2 = win[2];
  assign b3 = win[3];

  always_comb begin
    form_ok = 1'b1;
    len     = '0;
    rpos    = '0;
    rkind   = xld_pkg::REL_NONE;
    hm      = 1'b0;
    modrm   = '0;
    term    = 1'b0;
    if (b0 == xld_pkg::OP_TWO_BYTE) begin
      if (op16) form_ok = 1'b0;
      if (b1 >= 8'h80 && b1 <= 8'h8F) begin
        len   = P + LW'(6);
        rpos  = P + LW'(2);
        rkind = xld_pkg::REL_JCC32;
      end else begin
        if (!needs_modrm_ext(b1) || ad16) form_ok = 1'b0;
        hm    = 1'b1;
        modrm = b2;
        len   = P + LW'(3) + LW'(modrm_extra(b2, b3));
      end
    end else begin
      if (op16 && (b0 == xld_pkg::OP_CALL_REL || b0 == xld_pkg::OP_JMP_REL32))
        form_ok = 1'b0;
      priority if (b0 >= 8'h70 && b0 <= 8'h7F) begin
        len   = P + LW'(2);
        rpos  = P + LW'(1);
        rkind = xld_pkg::REL_JCC8;
      end else if (b0 >= 8'hB0 && b0 <= 8'hB7) begin
        len = P + LW'(2);
      end else if (b0 >= 8'hB8 && b0 <= 8'hBF) begin
        len = P + (op16 ? LW'(3) : LW'(5));
      end else if (b0 >= 8'h40 && b0 <= 8'h5F) begin
        len = P + LW'(1);
      end else if ((b0 < 8'h40 && (b0[2:0] == 3'd4 || b0[2:0] == 3'd5)) ||
                   b0 == 8'h68 || b0 == 8'h6A || b0 == 8'hA8 || b0 == 8'hA9) begin
        len = P + LW'(1) + LW'(imm_size(b0, op16, 3'd0));
      end else if (b0 == 8'h60 || b0 == 8'h61 || b0 == 8'h90 || b0 == 8'h9B ||
                   b0 == 8'h98 || b0 == 8'h99 || (b0 >= 8'h9C && b0 <= 8'h9F) ||
                   b0 == xld_pkg::OP_RET || b0 == 8'hC9 || b0 == 8'hCC) begin
        len  = P + LW'(1);
        term = (b0 == xld_pkg::OP_RET);
      end else if (b0 == xld_pkg::OP_RET_IMM || b0 == xld_pkg::OP_RETF_IMM) begin
        len  = P + LW'(3);
        term = 1'b1;
      end else if (b0 >= 8'hA0 && b0 <= 8'hA3) begin
        if (ad16) form_ok = 1'b0;
        len = P + LW'(5);
      end else if (b0 == xld_pkg::OP_CALL_REL) begin
        len   = P + LW'(5);
        rpos  = P + LW'(1);
        rkind = xld_pkg::REL_CALL32;
      end else if (b0 == xld_pkg::OP_JMP_REL32) begin
        len   = P + LW'(5);
        rpos  = P + LW'(1);
        rkind = xld_pkg::REL_JMP32;
        term  = 1'b1;
      end else if (b0 == xld_pkg::OP_JMP_REL8) begin
        len   = P + LW'(2);
        rpos  = P + LW'(1);
        rkind = xld_pkg::REL_JMP8;
        term  = 1'b1;
      end else begin
        if (!needs_modrm(b0) || ad16) form_ok = 1'b0;
        hm    = 1'b1;
        modrm = b1;
        if (b0 == xld_pkg::OP_GRP5) begin
          // FF /3 and FF /5 (far forms) are not supported; FF /4 is jmp indirect
          if (b1[5:3] == 3'd3 || b1[5:3] == 3'd5) form_ok = 1'b0;
          if (b1[5:3] == 3'd4) term = 1'b1;
        end
        len = P + LW'(2) + LW'(modrm_extra(b1, b2)) + LW'(imm_size(b0, op16, b1[5:3]));
      end
    end
  end

  always_comb begin
    res.ok        = form_ok && (len <= LW'(MAX_LEN));
    res.len       = len[3:0];
    res.rel_pos   = rpos[3:0];
    res.rel_kind  = rkind;
    res.has_modrm = hm;
    res.modrm     = modrm;
    res.ends_flow = term;
  end

endmodule

[design/xld_merge.sv]
// Merge stage: picks the lane at the opcode position and clears failed results.
module xld_merge #(
  parameter int MAX_LEN = 15
) (
  input  xld_pkg::lane_res_t       lanes [MAX_LEN],
  input  logic [$clog2(MAX_LEN)-1:0] pcnt,
  input  logic                     all_pre,
  output xld_pkg::lane_res_t       res,
  output logic [3:0]               prefix_count
);

  xld_pkg::lane_res_t sel;

  assign sel = lanes[pcnt];

  always_comb begin
    if (all_pre || !sel.ok) begin
      res          = '0;
      prefix_count = '0;
    end else begin
      res          = sel;
      prefix_count = 4'(pcnt);
    end
  end

endmodule

[design/x86_instruction_length_decoder_core.sv]
// Top level of the x86 instruction length decoder: prefix scan, lanes, merge, output.
// Decodes one 32-bit x86 instruction from a 15-byte code window per transaction and reports
// length, prefix count, relative branch field, ModRM byte and whether it ends control flow.
// An item passes through two register stages: the first holds the prefix count and the
// results of MAX_LEN decode lanes (one per possible opcode position, all working at once),
// the second holds the merged result. out_valid rises once the window has passed both stages,
// and a new window is accepted every cycle while the output side keeps up. Bytes
// at positions MAX_LEN and above are ignored; failures return all-zero fields.
module x86_instruction_length_decoder_core #(
  parameter int MAX_LEN = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_code_low,
  input  logic [55:0] in_code_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_decode_ok,
  output logic [3:0]  out_instr_length,
  output logic [3:0]  out_prefix_count,
  output logic [3:0]  out_rel_field_pos,
  output logic [2:0]  out_rel_kind,
  output logic        out_has_modrm,
  output logic [7:0]  out_modrm_byte,
  output logic        out_ends_flow
);

  localparam int LCW  = $clog2(MAX_LEN);
  localparam int WPAD = MAX_LEN + 3;

  logic [7:0]           win [WPAD];
  logic [MAX_LEN-1:0]   is_pre;
  logic [MAX_LEN-1:0]   is_opsz;
  logic [MAX_LEN-1:0]   is_adsz;
  logic [MAX_LEN-1:0]   op16_before;
  logic [MAX_LEN-1:0]   ad16_before;
  logic [LCW-1:0]       pcnt;
  logic                 found;

  xld_pkg::lane_res_t   lane_res [MAX_LEN];
  xld_pkg::lane_res_t   lane_res_r [MAX_LEN];
  logic [LCW-1:0]       pcnt_r;
  logic                 all_pre_r;
  logic                 s1_valid_r;

  xld_pkg::lane_res_t   mres;
  logic [3:0]           mpcnt;
  xld_pkg::lane_res_t   out_res_r;
  logic [3:0]           out_pcnt_r;
  logic                 out_valid_r;

  logic                 s2_en;
  logic                 s1_en;

  // Window bytes; positions at MAX_LEN and beyond read as zero
  always_comb begin
    for (int i = 0; i < WPAD; i++) begin
      if (i < MAX_LEN && i < 8)
        win[i] = in_code_low[8*i +: 8];
      else if (i < MAX_LEN)
        win[i] = in_code_high[8*(i-8) +: 8];
      else
        win[i] = 8'h00;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      is_opsz[i] = (win[i] == xld_pkg::PFX_OPSZ);
      is_adsz[i] = (win[i] == xld_pkg::PFX_ADSZ);
      is_pre[i]  = is_opsz[i] || is_adsz[i] ||
                   win[i] == xld_pkg::PFX_LOCK || win[i] == xld_pkg::PFX_REPNE ||
                   win[i] == xld_pkg::PFX_REP  || win[i] == xld_pkg::PFX_CS ||
                   win[i] == xld_pkg::PFX_SS   || win[i] == xld_pkg::PFX_DS ||
                   win[i] == xld_pkg::PFX_ES   || win[i] == xld_pkg::PFX_FS ||
                   win[i] == xld_pkg::PFX_GS;
    end
  end

  // Size prefixes seen ahead of each lane's opcode position
  always_comb begin
    op16_before[0] = 1'b0;
    ad16_before[0] = 1'b0;
    for (int i = 1; i < MAX_LEN; i++) begin
      op16_before[i] = op16_before[i-1] | is_opsz[i-1];
      ad16_before[i] = ad16_before[i-1] | is_adsz[i-1];
    end
  end

  // First byte that is not a prefix
  always_comb begin
    pcnt  = '0;
    found = 1'b0;
    for (int i = 0; i < MAX_LEN; i++) begin
      if (!found && !is_pre[i]) begin
        pcnt  = LCW'(i);
        found = 1'b1;
      end
    end
  end

  for (genvar p = 0; p < MAX_LEN; p++) begin : g_lane
    logic [7:0] lw [4];
    for (genvar k = 0; k < 4; k++) begin : g_byte
      assign lw[k] = win[p+k];
    end
    xld_lane #(
      .POS     (p),
      .MAX_LEN (MAX_LEN)
    ) u_lane (
      .win  (lw),
      .op16 (op16_before[p]),
      .ad16 (ad16_before[p]),
      .res  (lane_res[p])
    );
  end

  assign s2_en    = !out_valid_r || out_ready;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      lane_res_r <= lane_res;
      pcnt_r     <= pcnt;
      all_pre_r  <= !found;
    end
  end

  xld_merge #(
    .MAX_LEN (MAX_LEN)
  ) u_merge (
    .lanes        (lane_res_r),
    .pcnt         (pcnt_r),
    .all_pre      (all_pre_r),
    .res          (mres),
    .prefix_count (mpcnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid_r) begin
      out_res_r  <= mres;
      out_pcnt_r <= mpcnt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_decode_ok     = out_res_r.ok;
  assign out_instr_length  = out_res_r.len;
  assign out_prefix_count  = out_pcnt_r;
  assign out_rel_field_pos = out_res_r.rel_pos;
  assign out_rel_kind      = out_res_r.rel_kind;
  assign out_has_modrm     = out_res_r.has_modrm;
  assign out_modrm_byte    = out_res_r.modrm;
  assign out_ends_flow     = out_res_r.ends_flow;

endmodule
